[src/zzsg_pkg.sv]
`timescale 1ns / 1ps

package zzsg_pkg;

    // default largest grid side
    localparam int MAX_DIM_DEF = 64;

    // fixed field widths
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int ADDR_W     = 12;
    localparam int IDX_W      = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCAN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCAN_HEIGHT = 1'b1;

    // grid side after reset
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd8;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } zzsg_cfg_t;

    typedef struct packed {
        logic restart;
    } zzsg_in_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] raster_address;
        logic [IDX_W-1:0]  scan_index;
        logic              last;
    } zzsg_out_t;

endpackage

[src/zzsg_chan_if.sv]
`timescale 1ns / 1ps

interface zzsg_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/zigzag_scan_order_generator_unit.sv]
// the result of an accepted request is held in the output register until it is taken
// throughput: one request per cycle while the receiver takes results, set by the single next-cell and address stage
// the output register frees up in the same cycle its result is taken, so no bubbles
// reset: width and height go to 8, the walk is parked with the next request at (0,0)
// no clearing pass and no memories, the block is ready straight out of reset
`timescale 1ns / 1ps

module zigzag_scan_order_generator_unit #(
    parameter int MAX_DIM = zzsg_pkg::MAX_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    zzsg_chan_if.sink   cfg,
    zzsg_chan_if.sink   in_chan,
    zzsg_chan_if.source out_chan
);

    // coordinate width, and width that holds the side length itself
    localparam int CRD_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    // width for clamping the raw register value
    localparam int CLP_W = (DIM_W > zzsg_pkg::CFG_DATA_W) ? DIM_W : zzsg_pkg::CFG_DATA_W;
    // widths for address and coordinate outputs before trimming to field widths
    localparam int AFW   = ((CRD_W + DIM_W) > zzsg_pkg::ADDR_W) ?
                           (CRD_W + DIM_W) : zzsg_pkg::ADDR_W;
    localparam int CW    = (CRD_W > zzsg_pkg::COL_W) ? CRD_W : zzsg_pkg::COL_W;
    localparam int RW    = (CRD_W > zzsg_pkg::ROW_W) ? CRD_W : zzsg_pkg::ROW_W;

    // configuration registers
    logic [zzsg_pkg::CFG_DATA_W-1:0] scan_width_reg;
    logic [zzsg_pkg::CFG_DATA_W-1:0] scan_height_reg;

    // walk state: the last cell handed out
    logic [CRD_W-1:0]           cur_col_reg;
    logic [CRD_W-1:0]           cur_row_reg;
    logic                       going_dl_reg;
    logic [zzsg_pkg::IDX_W-1:0] count_reg;
    logic                       scan_done_reg;

    // result register
    logic                out_valid_reg;
    zzsg_pkg::zzsg_out_t out_reg;

    // handshakes
    logic cfg_acc;
    logic in_acc;
    logic out_acc;

    // clamped dimensions
    logic [CLP_W-1:0] w_ext;
    logic [CLP_W-1:0] h_ext;
    logic [CLP_W-1:0] w_clp;
    logic [CLP_W-1:0] h_clp;
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [DIM_W-1:0] dim_w_m1;
    logic [DIM_W-1:0] dim_h_m1;
    logic [CRD_W-1:0] xmax;
    logic [CRD_W-1:0] ymax;

    // next cell
    logic                       fresh;
    logic                       wrap;
    logic [CRD_W-1:0]           step_col;
    logic [CRD_W-1:0]           step_row;
    logic                       step_dl;
    logic [CRD_W-1:0]           cur_col_next;
    logic [CRD_W-1:0]           cur_row_next;
    logic                       going_dl_next;
    logic [zzsg_pkg::IDX_W-1:0] count_next;
    logic                       is_last;
    logic [AFW-1:0]             addr_full;
    logic [CW-1:0]              col_ext;
    logic [RW-1:0]              row_ext;
    zzsg_pkg::zzsg_out_t        out_next;

    assign cfg.ready     = 1'b1;
    assign cfg_acc       = cfg.valid && cfg.ready;
    // the result register empties in the same cycle it is taken
    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign in_acc        = in_chan.valid && in_chan.ready;
    assign out_chan.valid   = out_valid_reg;
    assign out_chan.payload = out_reg;
    assign out_acc       = out_valid_reg && out_chan.ready;

    // zero acts as one, anything beyond the largest side acts as the largest side
    assign w_ext = CLP_W'(scan_width_reg);
    assign h_ext = CLP_W'(scan_height_reg);

    always_comb
    begin
        w_clp = w_ext;
        if (w_ext == '0)
        begin
            w_clp = CLP_W'(1);
        end
        else if (w_ext > CLP_W'(MAX_DIM))
        begin
            w_clp = CLP_W'(MAX_DIM);
        end
        h_clp = h_ext;
        if (h_ext == '0)
        begin
            h_clp = CLP_W'(1);
        end
        else if (h_ext > CLP_W'(MAX_DIM))
        begin
            h_clp = CLP_W'(MAX_DIM);
        end
    end

    assign dim_w    = w_clp[DIM_W-1:0];
    assign dim_h    = h_clp[DIM_W-1:0];
    assign dim_w_m1 = dim_w - DIM_W'(1);
    assign dim_h_m1 = dim_h - DIM_W'(1);
    assign xmax     = dim_w_m1[CRD_W-1:0];
    assign ymax     = dim_h_m1[CRD_W-1:0];

    // one zigzag step from the current cell
    always_comb
    begin
        step_col = cur_col_reg;
        step_row = cur_row_reg;
        step_dl  = going_dl_reg;
        wrap     = 1'b0;
        if (going_dl_reg)
        begin
            if ((cur_col_reg != '0) && (cur_row_reg < ymax))
            begin
                // carry on down-left
                step_col = cur_col_reg - CRD_W'(1);
                step_row = cur_row_reg + CRD_W'(1);
            end
            else
            begin
                // diagonal ends: down, or right on the bottom row
                if (cur_row_reg < ymax)
                begin
                    step_row = cur_row_reg + CRD_W'(1);
                end
                else if (cur_col_reg < xmax)
                begin
                    step_col = cur_col_reg + CRD_W'(1);
                end
                else
                begin
                    wrap = 1'b1;
                end
                step_dl = 1'b0;
            end
        end
        else
        begin
            if ((cur_col_reg < xmax) && (cur_row_reg != '0))
            begin
                // carry on up-right
                step_col = cur_col_reg + CRD_W'(1);
                step_row = cur_row_reg - CRD_W'(1);
            end
            else
            begin
                // diagonal ends: right, or down on the right column
                if (cur_col_reg < xmax)
                begin
                    step_col = cur_col_reg + CRD_W'(1);
                end
                else if (cur_row_reg < ymax)
                begin
                    step_row = cur_row_reg + CRD_W'(1);
                end
                else
                begin
                    wrap = 1'b1;
                end
                step_dl = 1'b1;
            end
        end
    end

    // a restart request, a finished scan or a fresh configuration start over at (0,0)
    assign fresh = in_chan.payload.restart || scan_done_reg || wrap;

    always_comb
    begin
        if (fresh)
        begin
            cur_col_next  = '0;
            cur_row_next  = '0;
            going_dl_next = 1'b0;
            count_next    = '0;
        end
        else
        begin
            cur_col_next  = step_col;
            cur_row_next  = step_row;
            going_dl_next = step_dl;
            count_next    = count_reg + zzsg_pkg::IDX_W'(1);
        end
    end

    assign is_last   = (cur_col_next == xmax) && (cur_row_next == ymax);
    // raster address, one multiply and an add
    assign addr_full = (AFW'(cur_row_next) * AFW'(dim_w)) + AFW'(cur_col_next);
    assign col_ext   = CW'(cur_col_next);
    assign row_ext   = RW'(cur_row_next);

    always_comb
    begin
        out_next.column         = col_ext[zzsg_pkg::COL_W-1:0];
        out_next.row            = row_ext[zzsg_pkg::ROW_W-1:0];
        out_next.raster_address = addr_full[zzsg_pkg::ADDR_W-1:0];
        out_next.scan_index     = count_next;
        out_next.last           = is_last;
    end

    // configuration and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_width_reg  <= zzsg_pkg::DIM_RESET;
            scan_height_reg <= zzsg_pkg::DIM_RESET;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            going_dl_reg    <= 1'b0;
            count_reg       <= '0;
            scan_done_reg   <= 1'b1;
        end
        else
        begin
            if (in_acc)
            begin
                cur_col_reg   <= cur_col_next;
                cur_row_reg   <= cur_row_next;
                going_dl_reg  <= going_dl_next;
                count_reg     <= count_next;
                scan_done_reg <= is_last;
            end
            // any write to a listed register forces a new scan
            if (cfg_acc)
            begin
                case (cfg.payload.index)
                    zzsg_pkg::CFG_IDX_SCAN_WIDTH:
                    begin
                        scan_width_reg <= cfg.payload.data;
                        scan_done_reg  <= 1'b1;
                    end
                    zzsg_pkg::CFG_IDX_SCAN_HEIGHT:
                    begin
                        scan_height_reg <= cfg.payload.data;
                        scan_done_reg   <= 1'b1;
                    end
                    default:
                    begin
                        scan_done_reg <= scan_done_reg;
                    end
                endcase
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_reg <= out_next;
        end
    end

    // an accepted request always leaves a result waiting
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted request left no result");

    // a restart request always yields the origin with scan index zero
    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_chan.payload.restart |=>
            (out_reg.column == '0) && (out_reg.row == '0) && (out_reg.scan_index == '0))
        else $error("restart did not yield the origin");

    // the scan-finished flag tracks the last flag of the result just produced, unless a register is written
    a_done_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !cfg_acc |=> scan_done_reg == out_reg.last)
        else $error("scan finished flag out of step with result");

    // while a scan is live the current cell stays inside the grid
    a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        !scan_done_reg |-> (cur_col_reg <= xmax) && (cur_row_reg <= ymax))
        else $error("walk left the grid");

endmodule

[dv/tb_zigzag_scan_order_generator_unit.sv]
`timescale 1ns / 1ps

module tb_zigzag_scan_order_generator_unit;

    localparam int MAX_DIM       = zzsg_pkg::MAX_DIM_DEF;
    localparam int RANDOM_ITEMS  = 1030;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 48;
    localparam int MAX_REPORTED  = 10;

    // field widths taken over from the package
    localparam int CFG_DATA_W = zzsg_pkg::CFG_DATA_W;
    localparam int CFG_IDX_W  = zzsg_pkg::CFG_IDX_W;
    localparam int COL_W      = zzsg_pkg::COL_W;
    localparam int ROW_W      = zzsg_pkg::ROW_W;
    localparam int ADDR_W     = zzsg_pkg::ADDR_W;
    localparam int IDX_W      = zzsg_pkg::IDX_W;

    logic clk;
    logic rst_n;

    zzsg_chan_if #(.payload_t(zzsg_pkg::zzsg_cfg_t)) cfg_if ();
    zzsg_chan_if #(.payload_t(zzsg_pkg::zzsg_in_t))  req_if ();
    zzsg_chan_if #(.payload_t(zzsg_pkg::zzsg_out_t)) cell_if ();

    zigzag_scan_order_generator_unit #(
        .MAX_DIM (MAX_DIM)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_if),
        .in_chan  (req_if),
        .out_chan (cell_if)
    );

    // requests waiting for the driver, and cells the walk should emit next
    zzsg_pkg::zzsg_in_t  pending_reqs[$];
    zzsg_pkg::zzsg_out_t expected_cells[$];

    // idle rates in percent, changed by the stimulus between phases
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // long receiver hold-off, asked for by the stimulus and counted below
    int unsigned hold_asks;
    int unsigned hold_served;
    int unsigned hold_left;

    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned reqs_queued;

    // predicted walk: grid registers and position of the last emitted cell
    logic [CFG_DATA_W-1:0] grid_w;
    logic [CFG_DATA_W-1:0] grid_h;
    int                    walk_col;
    int                    walk_row;
    logic                  walk_down_left;
    logic [IDX_W-1:0]      walk_pos;
    logic                  walk_done;

    // register values as last written by the stimulus
    logic [CFG_DATA_W-1:0] set_w;
    logic [CFG_DATA_W-1:0] set_h;
    int                    phase_len;
    int                    cells_in_grid;
    int unsigned           pick;
    logic                  pressure_done;

    // clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // a register value of zero acts as one, anything above the largest side is clipped
    function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // mostly small grids so scans complete often, a few of the largest and out of range
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return CFG_DATA_W'($urandom_range(1, 6));
        else if (r < 75)
            return CFG_DATA_W'($urandom_range(7, 16));
        else if (r < 83)
            return CFG_DATA_W'(MAX_DIM);
        else if (r < 88)
            return '0;
        else if (r < 93)
            return CFG_DATA_W'($urandom_range(MAX_DIM + 1, 127));
        return CFG_DATA_W'($urandom_range(17, MAX_DIM - 1));
    endfunction

    // moves the predicted walk on by one request and returns the cell it lands on
    function automatic zzsg_pkg::zzsg_out_t next_cell(input logic restart);
        int                  w;
        int                  h;
        int                  x;
        int                  y;
        logic                fresh;
        zzsg_pkg::zzsg_out_t pos;
        w = eff_dim(grid_w);
        h = eff_dim(grid_h);
        x = walk_col;
        y = walk_row;
        fresh = restart || walk_done;
        if (!fresh)
        begin
            if (walk_down_left)
            begin
                if (x > 0 && y < h - 1)
                begin
                    x--;
                    y++;
                end
                else
                begin
                    // end of a down-left diagonal: down, else right, else wrap
                    if (y < h - 1)
                        y++;
                    else if (x < w - 1)
                        x++;
                    else
                        fresh = 1'b1;
                    walk_down_left = 1'b0;
                end
            end
            else
            begin
                if (x < w - 1 && y > 0)
                begin
                    x++;
                    y--;
                end
                else
                begin
                    // end of an up-right diagonal: right, else down, else wrap
                    if (x < w - 1)
                        x++;
                    else if (y < h - 1)
                        y++;
                    else
                        fresh = 1'b1;
                    walk_down_left = 1'b1;
                end
            end
        end
        if (fresh)
        begin
            x = 0;
            y = 0;
            walk_down_left = 1'b0;
            walk_pos = '0;
        end
        else
            walk_pos = walk_pos + 1'b1;
        walk_col = x;
        walk_row = y;
        walk_done = (x == w - 1) && (y == h - 1);
        pos.column = COL_W'(x);
        pos.row = ROW_W'(y);
        pos.raster_address = ADDR_W'(y * w + x);
        pos.scan_index = walk_pos;
        pos.last = walk_done;
        return pos;
    endfunction

    // request driver, fed from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_if.ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_if.valid <= 1'b1;
                req_if.payload <= pending_reqs.pop_front();
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // receiver ready, dropped at random and for the whole of a hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            cell_if.ready <= 1'b0;
        else
            cell_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // hold-off counter, so the block fills up while the driver keeps offering
    always @(posedge clk)
    begin
        if (hold_asks != hold_served)
        begin
            hold_served <= hold_asks;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // prediction on accepted requests and register writes, checking of accepted cells
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            grid_w = zzsg_pkg::DIM_RESET;
            grid_h = zzsg_pkg::DIM_RESET;
            walk_col = 0;
            walk_row = 0;
            walk_down_left = 1'b0;
            walk_pos = '0;
            walk_done = 1'b1;
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                // a write to either register parks the walk so the next request starts at (0,0)
                if (cfg_if.payload.index == zzsg_pkg::CFG_IDX_SCAN_WIDTH)
                    grid_w = cfg_if.payload.data;
                else if (cfg_if.payload.index == zzsg_pkg::CFG_IDX_SCAN_HEIGHT)
                    grid_h = cfg_if.payload.data;
                walk_done = 1'b1;
            end
            if (req_if.valid && req_if.ready)
                expected_cells.push_back(next_cell(req_if.payload.restart));
            if (cell_if.valid && cell_if.ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("unexpected cell col %0d row %0d addr %0d idx %0d last %0b",
                                 cell_if.payload.column, cell_if.payload.row,
                                 cell_if.payload.raster_address, cell_if.payload.scan_index,
                                 cell_if.payload.last);
                end
                else
                begin : compare
                    zzsg_pkg::zzsg_out_t want;
                    zzsg_pkg::zzsg_out_t got;
                    want = expected_cells.pop_front();
                    got = cell_if.payload;
                    if (got.column != want.column || got.row != want.row
                        || got.raster_address != want.raster_address
                        || got.scan_index != want.scan_index || got.last != want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTED)
                            $display({"cell mismatch: expected col %0d row %0d addr %0d ",
                                      "idx %0d last %0b, got col %0d row %0d addr %0d ",
                                      "idx %0d last %0b"},
                                     want.column, want.row, want.raster_address,
                                     want.scan_index, want.last, got.column, got.row,
                                     got.raster_address, got.scan_index, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n
            || (cfg_if.valid && cfg_if.ready)
            || (req_if.valid && req_if.ready)
            || (cell_if.valid && cell_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= '{index: idx, data: val};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_req(input logic restart);
        zzsg_pkg::zzsg_in_t req;
        req.restart = restart;
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    // registers are only written once every request has been answered
    task automatic drain();
        while (pending_reqs.size() != 0 || req_if.valid || expected_cells.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        drain();
        write_reg(zzsg_pkg::CFG_IDX_SCAN_WIDTH, w);
        write_reg(zzsg_pkg::CFG_IDX_SCAN_HEIGHT, h);
        set_w = w;
        set_h = h;
    endtask

    initial
    begin
        rst_n = 1'b0;
        clk = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        cell_if.ready = 1'b0;
        hold_asks = 0;
        hold_served = 0;
        hold_left = 0;
        mismatches = 0;
        quiet_cycles = 0;
        reqs_queued = 0;
        pressure_done = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 84;
        set_w = zzsg_pkg::DIM_RESET;
        set_h = zzsg_pkg::DIM_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid of 8 by 8, with a restart part way into the scan
        queue_req(1'b0);
        queue_req(1'b0);
        queue_req(1'b0);
        queue_req(1'b1);
        queue_req(1'b0);
        queue_req(1'b0);

        // one-cell grid, written mid-scan
        set_grid(CFG_DATA_W'(1), CFG_DATA_W'(1));
        queue_req(1'b0);
        queue_req(1'b0);
        queue_req(1'b1);

        // zero width acts as one, all-ones height clips to the largest side
        set_grid('0, '1);
        queue_req(1'b0);
        queue_req(1'b0);
        queue_req(1'b0);

        // small grid, one full scan and the wrap to a new one
        set_grid(CFG_DATA_W'(3), CFG_DATA_W'(2));
        repeat (7) queue_req(1'b0);

        // single column, so the first move goes down
        set_grid(CFG_DATA_W'(1), CFG_DATA_W'(3));
        repeat (4) queue_req(1'b0);

        reqs_queued = 0;
        while (reqs_queued < RANDOM_ITEMS)
        begin
            drain();
            // idling pattern by progress through the random part
            if (reqs_queued < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 84;
            end
            else if (reqs_queued < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // sometimes leave the grid alone so the walk carries on across the pause
            pick = $urandom_range(3);
            if (pick == 1 || pick == 3)
            begin
                set_w = pick_dim();
                write_reg(zzsg_pkg::CFG_IDX_SCAN_WIDTH, set_w);
            end
            if (pick == 2 || pick == 3)
            begin
                set_h = pick_dim();
                write_reg(zzsg_pkg::CFG_IDX_SCAN_HEIGHT, set_h);
            end

            // enough requests for a couple of full scans, capped on big grids
            cells_in_grid = eff_dim(set_w) * eff_dim(set_h);
            phase_len = cells_in_grid * 2 + $urandom_range(0, 5);
            if (phase_len > 150)
                phase_len = 150;

            if (!pressure_done && send_idle_pct == 0)
            begin
                if (phase_len < 80)
                    phase_len = 80;
                hold_asks++;
                pressure_done = 1'b1;
            end

            repeat (phase_len) queue_req($urandom_range(99) < 3);
        end

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/zzsg_pkg.sv
src/zzsg_chan_if.sv
src/zigzag_scan_order_generator_unit.sv
dv/tb_zigzag_scan_order_generator_unit.sv
